FILE: sv/spq_pkg.sv
// shared types and codes for the stable priority queue
`timescale 1ns / 1ps
package spq_pkg;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DEQ_EMPTY = 2'd1;
  localparam logic [1:0] ST_ENQ_FULL  = 2'd2;

  localparam logic signed [31:0] EMPTY_HEAD = -32'sd1;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] item_value;
    logic [7:0]        item_priority;
  } spq_in_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic              is_empty;
    logic              is_full;
    logic [4:0]        occupancy;
    logic [1:0]        status;
  } spq_out_t;

  // operation broadcast to every cell of the row
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

FILE: sv/spq_cell.sv
// one slot of the sorted row: holds an entry and trades it with its neighbors
`timescale 1ns / 1ps
module spq_cell #(
  parameter int PRIO_W = 8
) (
  input  logic               clk,
  input  spq_pkg::spq_ctl_t  ctl,
  input  logic [31:0]        new_value,
  input  logic [PRIO_W-1:0]  new_prio,
  input  logic               occupied,
  input  logic               left_ge,
  input  logic [31:0]        left_value,
  input  logic [PRIO_W-1:0]  left_prio,
  input  logic [31:0]        right_value,
  input  logic [PRIO_W-1:0]  right_prio,
  output logic [31:0]        value,
  output logic [PRIO_W-1:0]  prio,
  output logic               ge
);
  import spq_pkg::*;

  logic [31:0]       value_next;
  logic [PRIO_W-1:0] prio_next;

  // entry stays ahead of the new item when its priority is not lower
  assign ge = occupied && (prio >= new_prio);

  always_comb begin
    value_next = value;
    prio_next  = prio;
    if (ctl.enq) begin
      if (!ge) begin
        if (left_ge) begin
          value_next = new_value;
          prio_next  = new_prio;
        end else begin
          value_next = left_value;
          prio_next  = left_prio;
        end
      end
    end else if (ctl.deq) begin
      value_next = right_value;
      prio_next  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

FILE: sv/stable_priority_queue.sv
// stable priority queue built as a row of shifting cells
// the result is registered and valid in the cycle after the item is accepted
// throughput: one item per cycle while result_ready is high; every cell compares and shifts in the same cycle
// the result register frees the input as soon as the pending result is taken
// reset clears the entry count and the result valid; cell contents stay undefined
`timescale 1ns / 1ps
module stable_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  spq_pkg::spq_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output spq_pkg::spq_out_t result
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     item_fire;
  logic                     full;
  logic                     empty;
  spq_ctl_t                 ctl;
  logic [31:0]              prio_ext;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [31:0]              cell_value [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio  [DEPTH];
  logic [DEPTH-1:0]         cell_ge;
  logic [31:0]              head_next;
  logic [1:0]               status_next;
  spq_out_t                 result_next;

  assign item_ready = !result_valid || result_ready;
  assign item_fire  = item_valid && item_ready;
  assign full       = (count == CNT_W'(DEPTH));
  assign empty      = (count == '0);

  assign prio_ext = 32'(item.item_priority);
  assign new_prio = prio_ext[PRIORITY_BITS-1:0];

  assign ctl.enq = item_fire && (item.mode == MODE_ENQ) && !full;
  assign ctl.deq = item_fire && (item.mode == MODE_DEQ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     occ;
    logic                     l_ge;
    logic [31:0]              l_value;
    logic [PRIORITY_BITS-1:0] l_prio;
    logic [31:0]              r_value;
    logic [PRIORITY_BITS-1:0] r_prio;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign l_ge    = 1'b1;
      assign l_value = item.item_value;
      assign l_prio  = new_prio;
    end else begin : g_mid
      assign l_ge    = cell_ge[i-1];
      assign l_value = cell_value[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_value = cell_value[i];
      assign r_prio  = cell_prio[i];
    end else begin : g_inner
      assign r_value = cell_value[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .PRIO_W(PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_value  (item.item_value),
      .new_prio   (new_prio),
      .occupied   (occ),
      .left_ge    (l_ge),
      .left_value (l_value),
      .left_prio  (l_prio),
      .right_value(r_value),
      .right_prio (r_prio),
      .value      (cell_value[i]),
      .prio       (cell_prio[i]),
      .ge         (cell_ge[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    head_next   = empty ? EMPTY_HEAD : cell_value[0];
    if (ctl.enq) begin
      count_next = count + CNT_W'(1);
      head_next  = cell_ge[0] ? cell_value[0] : item.item_value;
    end else if (ctl.deq) begin
      count_next = count - CNT_W'(1);
      head_next  = (count > CNT_W'(1)) ? cell_value[1] : EMPTY_HEAD;
    end else if (item.mode == MODE_ENQ) begin
      status_next = ST_ENQ_FULL;
    end else begin
      status_next = ST_DEQ_EMPTY;
    end
  end

  always_comb begin
    result_next.head_value = head_next;
    result_next.is_empty   = (count_next == '0);
    result_next.is_full    = (count_next == CNT_W'(DEPTH));
    result_next.occupancy  = 5'(count_next);
    result_next.status     = status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (item_fire) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (item_fire && item.mode == MODE_ENQ && full) |=>
      (count == $past(count) && result.status == ST_ENQ_FULL))
    else $error("enqueue on full changed the queue");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.is_empty) |-> (result.head_value == EMPTY_HEAD))
    else $error("empty result without all-ones head");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    item_fire |=> (result.occupancy == 5'(count)))
    else $error("reported occupancy differs from entry count");
`endif

endmodule
